// ===== hdl/mblg_pkg.sv =====
package mblg_pkg;

  localparam int GAIN_W     = 15;
  localparam int OUT_W      = 32;
  localparam int REM_W      = 11;
  localparam int DEC_W      = 3;
  localparam int ACC_W      = 34;
  localparam int FRAC_W     = 30;
  localparam int POW_W      = 32;
  localparam int HI_W       = 64;
  localparam int LO_W       = POW_W;
  localparam int RECIP_W    = 31;
  localparam int QUO_W      = 31;
  localparam int P10_W      = 17;
  localparam int MUL_W      = 14;
  localparam int TOT_W      = 48;
  localparam int FRAC_SHIFT = 14;
  localparam int STEP_IDX_W = 4;
  localparam int NUM_STEPS  = 11;

  localparam int GAIN_LIMIT = 9632;
  localparam int DECADE_MB  = 2000;

  localparam logic [POW_W-1:0] Q30_ONE = POW_W'(1) << FRAC_W;

  typedef struct packed {
    logic [ACC_W-1:0]  acc;
    logic [FRAC_W-1:0] frac;
    logic [REM_W-1:0]  rem;
    logic [DEC_W-1:0]  dec;
    logic              neg;
  } mblg_acc_t;

  typedef struct packed {
    logic [TOT_W-1:0] hi;
    logic [MUL_W-1:0] lo;
  } mblg_prod_t;

  // 10^(2^k/2000) in Q30
  function automatic logic [POW_W-1:0] pow_step(input logic [STEP_IDX_W-1:0] k);
    logic [POW_W-1:0] f;
    case (k)
      4'd0:    f = 32'd1074978726;
      4'd1:    f = 32'd1076217054;
      4'd2:    f = 32'd1078697991;
      4'd3:    f = 32'd1083677034;
      4'd4:    f = 32'd1093704174;
      4'd5:    f = 32'd1114037653;
      4'd6:    f = 32'd1155845721;
      4'd7:    f = 32'd1244227712;
      4'd8:    f = 32'd1441782898;
      4'd9:    f = 32'd1935975557;
      4'd10:   f = 32'd3490598276;
      default: f = Q30_ONE;
    endcase
    return f;
  endfunction

  function automatic logic [P10_W-1:0] pow10(input logic [DEC_W-1:0] n);
    logic [P10_W-1:0] p;
    case (n)
      3'd0:    p = 17'd1;
      3'd1:    p = 17'd10;
      3'd2:    p = 17'd100;
      3'd3:    p = 17'd1000;
      3'd4:    p = 17'd10000;
      3'd5:    p = 17'd100000;
      default: p = 17'd1;
    endcase
    return p;
  endfunction

  // floor(2^34 / 10^n); estimate is at most one below the true quotient
  function automatic logic [RECIP_W-1:0] recip10(input logic [DEC_W-1:0] n);
    logic [RECIP_W-1:0] m;
    case (n)
      3'd1:    m = 31'd1717986918;
      3'd2:    m = 31'd171798691;
      3'd3:    m = 31'd17179869;
      3'd4:    m = 31'd1717986;
      3'd5:    m = 31'd171798;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ===== hdl/mblg_if.sv =====
interface mblg_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [mblg_pkg::GAIN_W-1:0] gain_millibels;

  modport source (output valid, output gain_millibels, input ready);
  modport sink (input valid, input gain_millibels, output ready);
endinterface

interface mblg_out_if;
  logic                        valid;
  logic                        ready;
  logic [mblg_pkg::OUT_W-1:0] linear_gain;

  modport source (output valid, output linear_gain, input ready);
  modport sink (input valid, input linear_gain, output ready);
endinterface

// ===== hdl/mblg_decade.sv =====
module mblg_decade (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [mblg_pkg::GAIN_W-1:0] in_gain,
  output logic                                out_valid,
  output mblg_pkg::mblg_acc_t                 out_st
);

  localparam int W = mblg_pkg::GAIN_W;
  localparam int D = mblg_pkg::DECADE_MB;
  localparam logic signed [W-1:0] POS_LIM = W'(mblg_pkg::GAIN_LIMIT);
  localparam logic signed [W-1:0] NEG_LIM = W'(-mblg_pkg::GAIN_LIMIT);
  localparam logic signed [W-1:0] P1 = W'(D);
  localparam logic signed [W-1:0] P2 = W'(2 * D);
  localparam logic signed [W-1:0] P3 = W'(3 * D);
  localparam logic signed [W-1:0] P4 = W'(4 * D);
  localparam logic signed [W-1:0] P5 = W'(5 * D);
  localparam logic signed [W-1:0] N1 = W'(-D);
  localparam logic signed [W-1:0] N2 = W'(-2 * D);
  localparam logic signed [W-1:0] N3 = W'(-3 * D);
  localparam logic signed [W-1:0] N4 = W'(-4 * D);

  logic signed [W-1:0]          mb;
  logic signed [W-1:0]          off;
  logic signed [W-1:0]          rem_full;
  logic [mblg_pkg::DEC_W-1:0]   dec;
  mblg_pkg::mblg_acc_t          st_nxt;
  mblg_pkg::mblg_acc_t          st_r;
  logic                         valid_r;

  always_comb begin
    mb = in_gain;
    if (in_gain < NEG_LIM) begin
      mb = NEG_LIM;
    end else if (in_gain > POS_LIM) begin
      mb = POS_LIM;
    end

    // count whole decades and bring the gain into 0..1999
    if (mb[W-1]) begin
      if (mb < N4) begin
        dec = 3'd5; off = P5;
      end else if (mb < N3) begin
        dec = 3'd4; off = P4;
      end else if (mb < N2) begin
        dec = 3'd3; off = P3;
      end else if (mb < N1) begin
        dec = 3'd2; off = P2;
      end else begin
        dec = 3'd1; off = P1;
      end
    end else begin
      if (mb >= P4) begin
        dec = 3'd4; off = N4;
      end else if (mb >= P3) begin
        dec = 3'd3; off = N3;
      end else if (mb >= P2) begin
        dec = 3'd2; off = N2;
      end else if (mb >= P1) begin
        dec = 3'd1; off = N1;
      end else begin
        dec = 3'd0; off = '0;
      end
    end
    rem_full = mb + off;

    st_nxt.acc  = mblg_pkg::ACC_W'(mblg_pkg::Q30_ONE);
    st_nxt.frac = '0;
    st_nxt.rem  = rem_full[mblg_pkg::REM_W-1:0];
    st_nxt.dec  = dec;
    st_nxt.neg  = mb[W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_st    = st_r;

`ifndef SYNTHESIS
  a_decade_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (st_r.rem < 11'(mblg_pkg::DECADE_MB)) &&
                ((st_r.neg && st_r.dec != 3'd0 && st_r.dec <= 3'd5) ||
                 (!st_r.neg && st_r.dec <= 3'd4)))
    else $error("decade count or remainder out of range");
`endif

endmodule

// ===== hdl/mblg_mul_step.sv =====
module mblg_mul_step #(
  parameter int unsigned BIT = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  mblg_pkg::mblg_acc_t in_st,
  output logic                out_valid,
  output mblg_pkg::mblg_acc_t out_st
);

  localparam int ACC_W  = mblg_pkg::ACC_W;
  localparam int FRAC_W = mblg_pkg::FRAC_W;
  localparam int POW_W  = mblg_pkg::POW_W;
  localparam int HI_W   = mblg_pkg::HI_W;
  localparam int LO_W   = mblg_pkg::LO_W;
  localparam int HIF_W  = ACC_W + POW_W;
  localparam int LOF_W  = FRAC_W + POW_W;

  logic [POW_W-1:0]           f;
  logic [HIF_W-1:0]           hi_full;
  logic [LOF_W-1:0]           lo_full;
  logic [HI_W-1:0]            hi_nxt;
  logic [LO_W-1:0]            lo_nxt;
  logic [HI_W-1:0]            hi_r;
  logic [LO_W-1:0]            lo_r;
  logic [mblg_pkg::REM_W-1:0] rem_r;
  logic [mblg_pkg::DEC_W-1:0] dec_r;
  logic                       neg_r;
  logic                       va_r;
  logic [HI_W-1:0]            sum;
  mblg_pkg::mblg_acc_t        st_nxt;
  mblg_pkg::mblg_acc_t        st_r;
  logic                       vb_r;

  // a clear bit multiplies by one in Q30, which leaves acc and frac unchanged
  assign f = in_st.rem[BIT] ? mblg_pkg::pow_step(mblg_pkg::STEP_IDX_W'(BIT))
                            : mblg_pkg::Q30_ONE;

  assign hi_full = HIF_W'(in_st.acc) * HIF_W'(f);
  assign lo_full = LOF_W'(in_st.frac) * LOF_W'(f);
  assign hi_nxt  = hi_full[HI_W-1:0];
  assign lo_nxt  = lo_full[LOF_W-1:FRAC_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hi_r  <= hi_nxt;
      lo_r  <= lo_nxt;
      rem_r <= in_st.rem;
      dec_r <= in_st.dec;
      neg_r <= in_st.neg;
    end
  end

  always_comb begin
    sum         = hi_r + HI_W'(lo_r);
    st_nxt.acc  = sum[HI_W-1:FRAC_W];
    st_nxt.frac = sum[FRAC_W-1:0];
    st_nxt.rem  = rem_r;
    st_nxt.dec  = dec_r;
    st_nxt.neg  = neg_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign out_valid = vb_r;
  assign out_st    = st_r;

endmodule

// ===== hdl/mblg_scale.sv =====
module mblg_scale (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  mblg_pkg::mblg_acc_t  in_st,
  output logic                 out_valid,
  output mblg_pkg::mblg_prod_t out_prod
);

  localparam int ACC_W   = mblg_pkg::ACC_W;
  localparam int FRAC_W  = mblg_pkg::FRAC_W;
  localparam int RECIP_W = mblg_pkg::RECIP_W;
  localparam int QUO_W   = mblg_pkg::QUO_W;
  localparam int P10_W   = mblg_pkg::P10_W;
  localparam int MUL_W   = mblg_pkg::MUL_W;
  localparam int TOT_W   = mblg_pkg::TOT_W;
  localparam int RP_W    = ACC_W + RECIP_W;
  localparam int QD_W    = QUO_W + P10_W;
  localparam int LOF_W   = FRAC_W + MUL_W;

  // divide stage 1: reciprocal product
  logic [RP_W-1:0]      rp_full;
  logic [QUO_W-1:0]     q1_nxt;
  logic [QUO_W-1:0]     q1_r;
  mblg_pkg::mblg_acc_t  st1_r;
  logic                 v1_r;
  // divide stage 2: back-multiply
  logic [QD_W-1:0]      qd_full;
  logic [ACC_W-1:0]     qd2_nxt;
  logic [ACC_W-1:0]     qd2_r;
  logic [QUO_W-1:0]     q2_r;
  mblg_pkg::mblg_acc_t  st2_r;
  logic                 v2_r;
  // divide stage 3: correction
  logic [ACC_W-1:0]     rem_w;
  logic [ACC_W-1:0]     divisor;
  logic                 fix;
  logic [QUO_W-1:0]     q_fix;
  mblg_pkg::mblg_acc_t  st3_nxt;
  mblg_pkg::mblg_acc_t  st3_r;
  logic                 v3_r;
  // decade multiply
  logic [MUL_W-1:0]     mulv;
  logic [TOT_W-1:0]     hi_full;
  logic [LOF_W-1:0]     lo_full;
  mblg_pkg::mblg_prod_t prod_nxt;
  mblg_pkg::mblg_prod_t prod_r;
  logic                 v4_r;

  assign rp_full = RP_W'(in_st.acc) * RP_W'(mblg_pkg::recip10(in_st.dec));
  assign q1_nxt  = rp_full[RP_W-1:ACC_W];

  assign qd_full = QD_W'(q1_r) * QD_W'(mblg_pkg::pow10(st1_r.dec));
  assign qd2_nxt = qd_full[ACC_W-1:0];

  always_comb begin
    rem_w   = st2_r.acc - qd2_r;
    divisor = ACC_W'(mblg_pkg::pow10(st2_r.dec));
    fix     = rem_w >= divisor;
    q_fix   = q2_r + QUO_W'(fix);
    st3_nxt = st2_r;
    // positive gains skip the divide
    if (st2_r.neg) begin
      st3_nxt.acc = ACC_W'(q_fix);
    end
  end

  always_comb begin
    mulv        = st3_r.neg ? MUL_W'(1) : MUL_W'(mblg_pkg::pow10(st3_r.dec));
    hi_full     = TOT_W'(st3_r.acc) * TOT_W'(mulv);
    lo_full     = LOF_W'(st3_r.frac) * LOF_W'(mulv);
    prod_nxt.hi = hi_full;
    prod_nxt.lo = lo_full[LOF_W-1:FRAC_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1_r   <= q1_nxt;
      st1_r  <= in_st;
      qd2_r  <= qd2_nxt;
      q2_r   <= q1_r;
      st2_r  <= st1_r;
      st3_r  <= st3_nxt;
      prod_r <= prod_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_prod  = prod_r;

`ifndef SYNTHESIS
  a_div_corrected: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && st2_r.neg) |-> (rem_w < (divisor << 1)))
    else $error("reciprocal quotient off by more than one");
`endif

endmodule

// ===== hdl/millibel_to_linear_gain_core.sv =====
// Channel  Dir  Payload                          Width
// in_ch    in   gain_millibels (signed mB)       15
// out_ch   out  linear_gain (unsigned, 16 frac)  32
//
// One gain per cycle unless the output stalls; the stages are clamp/decade, eleven
// Q30 multiply steps of two stages each, decade divide and multiply, and output.
// Reset: synchronous, active low; clears all valid bits, payload is not reset.
// Stall: the whole pipe holds only while a result waits at the output and the
// stage behind it is full; a bubble in that stage lets the pipe advance.
module millibel_to_linear_gain_core (
  input  logic              clk,
  input  logic              rst_n,
  mblg_in_if.sink           in_ch,
  mblg_out_if.source        out_ch
);

  localparam int NS    = mblg_pkg::NUM_STEPS;
  localparam int TOT_W = mblg_pkg::TOT_W;
  localparam int OUT_W = mblg_pkg::OUT_W;
  localparam int FS    = mblg_pkg::FRAC_SHIFT;

  logic                  en;
  logic                  dec_v;
  mblg_pkg::mblg_acc_t   dec_st;
  logic [NS:0]           step_v;
  mblg_pkg::mblg_acc_t   step_st [NS+1];
  logic                  scale_v;
  mblg_pkg::mblg_prod_t  scale_prod;
  logic [TOT_W-1:0]      total;
  logic [OUT_W-1:0]      gain_nxt;
  logic [OUT_W-1:0]      gain_r;
  logic                  out_valid_nxt;
  logic                  out_valid_r;

  // advance unless a waiting result would be overwritten
  assign en          = out_ch.ready || !out_valid_r || !scale_v;
  assign in_ch.ready = en;

  mblg_decade u_decade (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .in_gain   (in_ch.gain_millibels),
    .out_valid (dec_v),
    .out_st    (dec_st)
  );

  assign step_v[0]  = dec_v;
  assign step_st[0] = dec_st;

  // bits are taken from the top down
  for (genvar i = 0; i < NS; i++) begin : g_step
    mblg_mul_step #(
      .BIT (NS - 1 - i)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (step_v[i]),
      .in_st     (step_st[i]),
      .out_valid (step_v[i+1]),
      .out_st    (step_st[i+1])
    );
  end

  mblg_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (step_v[NS]),
    .in_st     (step_st[NS]),
    .out_valid (scale_v),
    .out_prod  (scale_prod)
  );

  assign total    = scale_prod.hi + TOT_W'(scale_prod.lo);
  assign gain_nxt = total[FS+OUT_W-1:FS];

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (en) begin
      out_valid_nxt = scale_v || (out_valid_r && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && scale_v) begin
      gain_r <= gain_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.linear_gain = gain_r;

`ifndef SYNTHESIS
  a_in_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> dec_v)
    else $error("accepted gain did not enter the pipe");

  a_hold_reason: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_valid_r && !out_ch.ready && scale_v))
    else $error("pipe held without a waiting result");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (scale_v && en) |=> out_valid_r)
    else $error("finished item lost before the output");
`endif

endmodule

// ===== test/millibel_to_linear_gain_core_tb.sv =====
module millibel_to_linear_gain_core_tb;

  localparam int GAIN_W      = mblg_pkg::GAIN_W;
  localparam int OUT_W       = mblg_pkg::OUT_W;
  localparam int GAIN_LIMIT  = mblg_pkg::GAIN_LIMIT;
  localparam int DECADE_MB   = mblg_pkg::DECADE_MB;
  localparam int FRAC_SHIFT  = mblg_pkg::FRAC_SHIFT;
  localparam int PIPE_DEPTH  = 28;
  localparam int STALL_LIMIT = 5000;
  localparam int MB_MIN      = -(1 << (GAIN_W - 1));
  localparam int MB_MAX      = (1 << (GAIN_W - 1)) - 1;

  // 10^(2^k/2000) in Q30, indexed by remainder bit
  localparam bit [31:0] DB_STEP [11] = '{
    32'd1074978726, 32'd1076217054, 32'd1078697991, 32'd1083677034,
    32'd1093704174, 32'd1114037653, 32'd1155845721, 32'd1244227712,
    32'd1441782898, 32'd1935975557, 32'd3490598276
  };

  typedef struct {
    logic signed [GAIN_W-1:0] mb;
    logic [OUT_W-1:0]         gain;
  } gain_req_t;

  logic clk;
  logic rst_n;

  mblg_in_if  in_ch ();
  mblg_out_if out_ch ();

  millibel_to_linear_gain_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  gain_req_t pending_gains[$];
  int        mismatches;
  int        idle_cycles;
  bit        src_idle_en;
  bit        snk_idle_en;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [OUT_W-1:0] millibels_to_gain(
    input logic signed [GAIN_W-1:0] mb_in
  );
    int        mb;
    bit [63:0] mul;
    bit [63:0] div;
    bit [63:0] acc;
    bit [63:0] frac;
    bit [63:0] f;
    bit [63:0] total;
    mb   = int'(mb_in);
    mul  = 64'd1;
    div  = 64'd1;
    acc  = 64'd1 << 30;
    frac = 64'd0;
    if (mb < -GAIN_LIMIT) mb = -GAIN_LIMIT;
    if (mb > GAIN_LIMIT) mb = GAIN_LIMIT;
    while (mb < 0) begin
      div = div * 10;
      mb  = mb + DECADE_MB;
    end
    while (mb >= DECADE_MB) begin
      mul = mul * 10;
      mb  = mb - DECADE_MB;
    end
    // walk remainder bits from the largest step down, carrying the Q30 fraction
    for (int k = 10; k >= 0; k--) begin
      if (mb[k]) begin
        f    = 64'(DB_STEP[k]);
        acc  = acc * f + ((frac * f) >> 30);
        frac = acc & ((64'd1 << 30) - 1);
        acc  = acc >> 30;
      end
    end
    total = (acc * mul + ((frac * mul) >> 30)) / div;
    return total[FRAC_SHIFT +: OUT_W];
  endfunction

  task automatic send_gain(input int mb);
    gain_req_t req;
    @(negedge clk);
    while (src_idle_en && $urandom_range(0, 99) < 10) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid          = 1'b1;
    in_ch.gain_millibels = GAIN_W'(mb);
    do @(posedge clk); while (!in_ch.ready);
    req.mb   = GAIN_W'(mb);
    req.gain = millibels_to_gain(req.mb);
    pending_gains.push_back(req);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_gains.size() != 0) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    gain_req_t req;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_gains.size() == 0) begin
        $display("%0t: unexpected result: expected none, got %h", $time, out_ch.linear_gain);
        mismatches++;
      end else begin
        req = pending_gains.pop_front();
        if (out_ch.linear_gain !== req.gain) begin
          $display("%0t: gain %0d mB: expected %h, got %h",
                   $time, req.mb, req.gain, out_ch.linear_gain);
          mismatches++;
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ch.ready = !snk_idle_en || ($urandom_range(0, 99) >= 10);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("millibel_to_linear_gain_core_tb: FAIL");
        $finish;
      end
    end
  end

  task automatic test_clamp_extremes();
    send_gain(MB_MIN);
    send_gain(MB_MAX);
    send_gain(-GAIN_LIMIT - 1);
    send_gain(-GAIN_LIMIT);
    send_gain(GAIN_LIMIT);
    send_gain(GAIN_LIMIT + 1);
  endtask

  task automatic test_decade_edges();
    send_gain(0);
    send_gain(-1);
    send_gain(1999);
    send_gain(2000);
    send_gain(-2000);
    send_gain(-2001);
    send_gain(8000);
    send_gain(-8000);
  endtask

  task automatic test_remainder_bits();
    // one set bit at a time, then 9999 mB, which clamps to the top of the range
    for (int k = 0; k <= 10; k++) send_gain(1 << k);
    send_gain(DECADE_MB - 1 + 4 * DECADE_MB);
  endtask

  task automatic test_random_range(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_gain($urandom_range(0, 2 * 200) - 200 +
                  ($urandom_range(0, 1) ? GAIN_LIMIT : -GAIN_LIMIT));
      else
        send_gain($urandom_range(0, 2 * GAIN_LIMIT) - GAIN_LIMIT);
      if (i == count / 2) wait_drained();
    end
  endtask

  task automatic test_random_field(input int count);
    for (int i = 0; i < count; i++) send_gain($urandom_range(0, MB_MAX - MB_MIN) + MB_MIN);
  endtask

  task automatic test_back_to_back(input int count);
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    test_random_range(count);
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
  endtask

  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.gain_millibels = '0;
    out_ch.ready         = 1'b0;
    mismatches           = 0;
    idle_cycles          = 0;
    src_idle_en          = 1'b1;
    snk_idle_en          = 1'b1;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_clamp_extremes();
    test_decade_edges();
    test_remainder_bits();
    test_random_range(900);
    test_back_to_back(350);
    test_random_field(300);
    test_random_range(350);

    wait_drained();
    repeat (2 * PIPE_DEPTH) @(posedge clk);
    if (mismatches == 0)
      $display("millibel_to_linear_gain_core_tb: PASS");
    else
      $display("millibel_to_linear_gain_core_tb: FAIL");
    $finish;
  end

endmodule
